// ----- rtl/spc_pkg.sv -----
// Package with shared widths and lane types for the sphere pair collision pipeline.
`timescale 1ns / 1ps
package spc_pkg;

  // Field and register widths.
  localparam int FLD_W = 32;
  localparam int CFG_W = 24;
  localparam logic [CFG_W-1:0] CONTACT_RESET = 24'd131072;

  // Three spatial components are processed side by side.
  localparam int LANES = 3;

  // Divider sizes: the quotient is below 2^33 on a hit, the divisor below 2^48.
  localparam int QW    = 34;
  localparam int RW    = 48;
  localparam int NUM_W = QW + RW;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [RW-1:0]    rem_t;
  typedef logic [QW-1:0]    quo_t;

endpackage

// ----- rtl/spc_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing a divisor.
`timescale 1ns / 1ps
module spc_div_pipe (
  input  logic                               clk,
  input  spc_pkg::num_t [spc_pkg::LANES-1:0] num_i,
  input  spc_pkg::rem_t                      den_i,
  output spc_pkg::quo_t [spc_pkg::LANES-1:0] q_o,
  output spc_pkg::rem_t [spc_pkg::LANES-1:0] rem_o,
  output spc_pkg::rem_t                      den_o
);
  import spc_pkg::*;

  // Per-stage registers: partial remainder, numerator bits still to shift in
  // (upper part) with quotient bits collected in the lower part, and the divisor.
  rem_t                 den_r  [QW];
  rem_t [LANES-1:0]     rem_r  [QW];
  quo_t [LANES-1:0]     work_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    rem_t             den_in;
    rem_t [LANES-1:0] rem_in;
    quo_t [LANES-1:0] work_in;
    rem_t [LANES-1:0] rem_nxt;
    quo_t [LANES-1:0] work_nxt;

    if (k == 0) begin : g_first
      // The top numerator bits form the starting remainder; it is below the divisor.
      always_comb begin
        den_in = den_i;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l]  = num_i[l][NUM_W-1:QW];
          work_in[l] = num_i[l][QW-1:0];
        end
      end
    end else begin : g_next
      assign den_in  = den_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
    end

    // One trial subtraction per lane.
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        logic [RW:0] trial;
        logic        ge;
        trial       = {rem_in[l], work_in[l][QW-1]};
        ge          = (trial >= {1'b0, den_in});
        rem_nxt[l]  = ge ? RW'(trial - {1'b0, den_in}) : trial[RW-1:0];
        work_nxt[l] = {work_in[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      den_r[k]  <= den_in;
      rem_r[k]  <= rem_nxt;
      work_r[k] <= work_nxt;
    end
  end

  assign q_o   = work_r[QW-1];
  assign rem_o = rem_r[QW-1];
  assign den_o = den_r[QW-1];

endmodule

// ----- rtl/sphere_pair_elastic_collision_top.sv -----
// Top level of the equal-mass sphere pair elastic collision pipeline.
`timescale 1ns / 1ps
//
//  Channel   Handshake          Payload
//  input     start / busy       in_first_*, in_second_* positions and velocities
//  result    out_valid strobe   out_first_new_vel_*, out_second_new_vel_*, out_collided
//  config    cfg_we             cfg_wdata (contact distance, Q8.16)
//
// One item is accepted every cycle; busy is always low.
// Each accepted item passes through six arithmetic stages, a 34-stage divider
// (one quotient bit per stage), rounding and output before its result appears.
// Synchronous reset clears the valid pipeline and sets the contact distance to 2.0.
// The receiver cannot stall, so the pipeline never holds.
module sphere_pair_elastic_collision_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [spc_pkg::FLD_W-1:0] in_first_pos_x,
  input  logic signed [spc_pkg::FLD_W-1:0] in_first_pos_y,
  input  logic signed [spc_pkg::FLD_W-1:0] in_first_pos_z,
  input  logic signed [spc_pkg::FLD_W-1:0] in_first_vel_x,
  input  logic signed [spc_pkg::FLD_W-1:0] in_first_vel_y,
  input  logic signed [spc_pkg::FLD_W-1:0] in_first_vel_z,
  input  logic signed [spc_pkg::FLD_W-1:0] in_second_pos_x,
  input  logic signed [spc_pkg::FLD_W-1:0] in_second_pos_y,
  input  logic signed [spc_pkg::FLD_W-1:0] in_second_pos_z,
  input  logic signed [spc_pkg::FLD_W-1:0] in_second_vel_x,
  input  logic signed [spc_pkg::FLD_W-1:0] in_second_vel_y,
  input  logic signed [spc_pkg::FLD_W-1:0] in_second_vel_z,
  input  logic                          cfg_we,
  input  logic [spc_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic signed [spc_pkg::FLD_W-1:0] out_first_new_vel_x,
  output logic signed [spc_pkg::FLD_W-1:0] out_first_new_vel_y,
  output logic signed [spc_pkg::FLD_W-1:0] out_first_new_vel_z,
  output logic signed [spc_pkg::FLD_W-1:0] out_second_new_vel_x,
  output logic signed [spc_pkg::FLD_W-1:0] out_second_new_vel_y,
  output logic signed [spc_pkg::FLD_W-1:0] out_second_new_vel_z,
  output logic                          out_collided
);
  import spc_pkg::*;

  localparam int LAT = QW + 8;

  // Data that rides alongside the arithmetic.
  typedef struct packed {
    logic                        hit;
    logic [LANES-1:0]            flip;
    logic [LANES-1:0][FLD_W-1:0] va;
    logic [LANES-1:0][FLD_W-1:0] vb;
  } side_t;

  function automatic logic [FLD_W-1:0] sat32(input logic [FLD_W+5:0] x);
    logic [FLD_W-1:0] res;
    if (x[FLD_W+5:FLD_W-1] == '0 || x[FLD_W+5:FLD_W-1] == '1) begin
      res = x[FLD_W-1:0];
    end else if (x[FLD_W+5]) begin
      res = {1'b1, {(FLD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(FLD_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic [LANES-1:0][FLD_W-1:0] pa, pb, va, vb;
  logic [CFG_W-1:0] cfg_r;
  logic [LAT-1:0]   vld_r;

  assign busy = 1'b0;
  assign pa = {in_first_pos_z, in_first_pos_y, in_first_pos_x};
  assign pb = {in_second_pos_z, in_second_pos_y, in_second_pos_x};
  assign va = {in_first_vel_z, in_first_vel_y, in_first_vel_x};
  assign vb = {in_second_vel_z, in_second_vel_y, in_second_vel_x};

  // Contact distance register and the valid bits that follow each item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CONTACT_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  // Stage 1: position and velocity differences.
  logic [LANES-1:0][FLD_W:0] d1_r, w1_r;
  side_t side1_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      d1_r[l] <= {pa[l][FLD_W-1], pa[l]} - {pb[l][FLD_W-1], pb[l]};
      w1_r[l] <= {va[l][FLD_W-1], va[l]} - {vb[l][FLD_W-1], vb[l]};
    end
    side1_r <= '{hit: 1'b0, flip: '0, va: va, vb: vb};
  end

  // Stage 2: box test against the contact distance, squares and dot-product terms.
  logic                     near2_nxt, near2_r;
  logic [LANES-1:0][47:0]   sq2_nxt, sq2_r;
  logic [LANES-1:0][57:0]   wd2_nxt, wd2_r;
  logic [LANES-1:0][24:0]   dt2_r;
  logic [47:0]              cc2_r;
  side_t                    side2_r;

  always_comb begin
    logic signed [33:0] cpos, cneg;
    cpos = $signed({10'd0, cfg_r});
    cneg = -cpos;
    near2_nxt = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      logic signed [33:0] dx;
      logic signed [24:0] dt;
      logic signed [49:0] sqf;
      logic signed [57:0] wdf;
      dx = $signed({d1_r[l][FLD_W], d1_r[l]});
      if (dx > cpos || dx < cneg) begin
        near2_nxt = 1'b0;
      end
      dt = $signed(d1_r[l][24:0]);
      sqf = dt * dt;
      sq2_nxt[l] = sqf[47:0];
      wdf = $signed(w1_r[l]) * dt;
      wd2_nxt[l] = wdf;
    end
  end

  always_ff @(posedge clk) begin
    near2_r <= near2_nxt;
    sq2_r   <= sq2_nxt;
    wd2_r   <= wd2_nxt;
    for (int l = 0; l < LANES; l++) begin
      dt2_r[l] <= d1_r[l][24:0];
    end
    cc2_r   <= {24'd0, cfg_r} * {24'd0, cfg_r};
    side2_r <= side1_r;
  end

  // Stage 3: squared distance, dot product and the contact decision.
  logic [49:0]            dsum3;
  logic [59:0]            s3_nxt, s3_r;
  logic [47:0]            den3_r;
  logic [LANES-1:0][23:0] dmag3_nxt, dmag3_r;
  logic [LANES-1:0]       dneg3_r;
  side_t                  side3_nxt, side3_r;

  always_comb begin
    dsum3  = 50'(sq2_r[0]) + 50'(sq2_r[1]) + 50'(sq2_r[2]);
    s3_nxt = 60'($signed(wd2_r[0])) + 60'($signed(wd2_r[1])) + 60'($signed(wd2_r[2]));
    side3_nxt = side2_r;
    side3_nxt.hit = near2_r && (dsum3 <= {2'b0, cc2_r}) && (dsum3 != '0);
    for (int l = 0; l < LANES; l++) begin
      dmag3_nxt[l] = dt2_r[l][24] ? 24'(-dt2_r[l]) : dt2_r[l][23:0];
    end
  end

  always_ff @(posedge clk) begin
    s3_r    <= s3_nxt;
    den3_r  <= dsum3[47:0];
    dmag3_r <= dmag3_nxt;
    for (int l = 0; l < LANES; l++) begin
      dneg3_r[l] <= dt2_r[l][24];
    end
    side3_r <= side3_nxt;
  end

  // Stage 4: magnitude of the dot product and the sign of each exchange term.
  logic [58:0]            smag4_r;
  logic [LANES-1:0][23:0] dmag4_r;
  logic [47:0]            den4_r;
  side_t                  side4_nxt, side4_r;

  always_comb begin
    side4_nxt = side3_r;
    for (int l = 0; l < LANES; l++) begin
      side4_nxt.flip[l] = s3_r[59] ^ dneg3_r[l];
    end
  end

  always_ff @(posedge clk) begin
    smag4_r <= s3_r[59] ? 59'(-s3_r) : s3_r[58:0];
    dmag4_r <= dmag3_r;
    den4_r  <= den3_r;
    side4_r <= side4_nxt;
  end

  // Stage 5: partial products of |s| * |d|.
  logic [LANES-1:0][53:0] pl5_r;
  logic [LANES-1:0][52:0] ph5_r;
  logic [47:0]            den5_r;
  side_t                  side5_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      pl5_r[l] <= {24'd0, smag4_r[29:0]} * {30'd0, dmag4_r[l]};
      ph5_r[l] <= {24'd0, smag4_r[58:30]} * {29'd0, dmag4_r[l]};
    end
    den5_r  <= den4_r;
    side5_r <= side4_r;
  end

  // Stage 6: full numerator.
  num_t [LANES-1:0] num6_nxt, num6_r;
  rem_t             den6_r;
  side_t            side6_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [82:0] acc;
      acc = {ph5_r[l], 30'd0} + {29'd0, pl5_r[l]};
      num6_nxt[l] = acc[NUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    num6_r  <= num6_nxt;
    den6_r  <= den5_r;
    side6_r <= side5_r;
  end

  // Division pipeline and the matching delay line for the side data.
  quo_t [LANES-1:0] q_d;
  rem_t [LANES-1:0] rem_d;
  rem_t             den_d;
  side_t            sdl_r [QW];

  spc_div_pipe u_div (
    .clk   (clk),
    .num_i (num6_r),
    .den_i (den6_r),
    .q_o   (q_d),
    .rem_o (rem_d),
    .den_o (den_d)
  );

  always_ff @(posedge clk) begin
    sdl_r[0] <= side6_r;
    for (int k = 1; k < QW; k++) begin
      sdl_r[k] <= sdl_r[k-1];
    end
  end

  // Round to nearest, ties away from zero.
  logic [LANES-1:0][QW:0] qr_r;
  side_t                  side7_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      qr_r[l] <= (QW+1)'(q_d[l]) + (QW+1)'({rem_d[l], 1'b0} >= {1'b0, den_d});
    end
    side7_r <= sdl_r[QW-1];
  end

  // Output stage: apply the exchange and saturate, or pass velocities through.
  logic [LANES-1:0][FLD_W-1:0] na_nxt, nb_nxt, na_r, nb_r;
  logic                        coll_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [FLD_W+5:0] a, b, q;
      a = (FLD_W+6)'($signed(side7_r.va[l]));
      b = (FLD_W+6)'($signed(side7_r.vb[l]));
      q = {3'd0, qr_r[l]};
      if (side7_r.hit) begin
        na_nxt[l] = sat32(side7_r.flip[l] ? a + q : a - q);
        nb_nxt[l] = sat32(side7_r.flip[l] ? b - q : b + q);
      end else begin
        na_nxt[l] = side7_r.va[l];
        nb_nxt[l] = side7_r.vb[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    na_r   <= na_nxt;
    nb_r   <= nb_nxt;
    coll_r <= side7_r.hit;
  end

  assign out_valid            = vld_r[LAT-1];
  assign out_collided         = coll_r & vld_r[LAT-1];
  assign out_first_new_vel_x  = na_r[0];
  assign out_first_new_vel_y  = na_r[1];
  assign out_first_new_vel_z  = na_r[2];
  assign out_second_new_vel_x = nb_r[0];
  assign out_second_new_vel_y = nb_r[1];
  assign out_second_new_vel_z = nb_r[2];

  // A result strobe always traces back to an accepted item.
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching accepted item");

  // Without a collision the first velocity passes through unchanged.
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_collided) |-> (out_first_new_vel_x == $past(in_first_vel_x, LAT)))
    else $error("velocity altered without a collision");

  // The divider remainder stays below the divisor for colliding items.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[QW+5] && sdl_r[QW-1].hit) |-> (rem_d[0] < den_d))
    else $error("divider remainder out of range");

endmodule

// ----- test/sphere_pair_collision_checker.sv -----
// Checker that predicts and compares the results of the sphere pair collision block.
`timescale 1ns / 1ps
module sphere_pair_collision_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [11:0][31:0]            pair,
  input  logic                         cfg_we,
  input  logic [spc_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         out_valid,
  input  logic [5:0][31:0]             new_vel,
  input  logic                         out_collided,
  output int                           fail_count,
  output int                           pending,
  output int                           hit_count,
  output int                           result_count
);

  typedef struct packed {
    logic [5:0][31:0] vel;
    logic             hit;
  } outcome_t;

  outcome_t expected_outcomes[$];
  logic [spc_pkg::CFG_W-1:0] contact;

  // Saturate a wide value to the signed 32-bit range.
  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Exchange the velocity components along the line of centers on contact.
  function automatic outcome_t collide(input logic [11:0][31:0] f,
                                       input logic [spc_pkg::CFG_W-1:0] c);
    longint d[3], w[3], v1[3], v2[3];
    longint cc, dsq, s, delta;
    logic [127:0] smag, dmag, num, quo, rem, den;
    outcome_t o;
    cc = longint'(c);
    o.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      v1[i] = longint'($signed(f[3+i]));
      v2[i] = longint'($signed(f[9+i]));
      d[i] = longint'($signed(f[i])) - longint'($signed(f[6+i]));
      w[i] = v1[i] - v2[i];
      if (d[i] > cc || d[i] < -cc) o.hit = 1'b0;
    end
    if (o.hit) begin
      dsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      if (dsq > cc * cc || dsq == 0) o.hit = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      o.vel[i] = f[3+i];
      o.vel[3+i] = f[9+i];
    end
    if (o.hit) begin
      s = w[0] * d[0] + w[1] * d[1] + w[2] * d[2];
      smag = (s < 0) ? 128'(-s) : 128'(s);
      den = 128'(dsq);
      for (int i = 0; i < 3; i++) begin
        dmag = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
        num = smag * dmag;
        quo = num / den;
        rem = num % den;
        // Round to nearest, ties away from zero.
        if (2 * rem >= den) quo = quo + 1;
        delta = ((s < 0) != (d[i] < 0)) ? -longint'(quo) : longint'(quo);
        o.vel[i] = clamp32(v1[i] - delta);
        o.vel[3+i] = clamp32(v2[i] + delta);
      end
    end
    return o;
  endfunction

  // Track the register, queue expectations and compare each result.
  always @(posedge clk) begin
    outcome_t want;
    string names[6];
    int errs;
    names = '{"first_new_vel_x", "first_new_vel_y", "first_new_vel_z",
              "second_new_vel_x", "second_new_vel_y", "second_new_vel_z"};
    errs = 0;
    if (!rst_n) begin
      contact <= spc_pkg::CONTACT_RESET;
      expected_outcomes.delete();
      fail_count <= 0;
      hit_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) contact <= cfg_wdata;
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_outcomes.size() == 0) begin
          $error("result item with no expectation waiting");
          errs++;
        end else begin
          want = expected_outcomes.pop_front();
          if (want.hit) hit_count <= hit_count + 1;
          for (int i = 0; i < 6; i++)
            if (new_vel[i] !== want.vel[i]) begin
              $error("%s expected %h actual %h", names[i], want.vel[i], new_vel[i]);
              errs++;
            end
          if (out_collided !== want.hit) begin
            $error("collided expected %b actual %b", want.hit, out_collided);
            errs++;
          end
        end
      end
      if (start && !busy) expected_outcomes.push_back(collide(pair, contact));
      fail_count <= fail_count + errs;
    end
    pending = expected_outcomes.size();
  end

endmodule

// ----- test/tb_sphere_pair_elastic_collision_top.sv -----
// Testbench top for the sphere pair collision block: stimulus, phases and verdict.
`timescale 1ns / 1ps
module tb_sphere_pair_elastic_collision_top;

  localparam int LATENCY = 41;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [11:0][31:0] pair;
  logic cfg_we;
  logic [spc_pkg::CFG_W-1:0] cfg_wdata;
  logic out_valid;
  logic [5:0][31:0] new_vel;
  logic out_collided;
  int fail_count, pending, hit_count, result_count;
  int cycles;
  int items_sent;
  int idle_pct;
  logic [spc_pkg::CFG_W-1:0] contact_now;

  sphere_pair_elastic_collision_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_pos_x(pair[0]), .in_first_pos_y(pair[1]), .in_first_pos_z(pair[2]),
    .in_first_vel_x(pair[3]), .in_first_vel_y(pair[4]), .in_first_vel_z(pair[5]),
    .in_second_pos_x(pair[6]), .in_second_pos_y(pair[7]), .in_second_pos_z(pair[8]),
    .in_second_vel_x(pair[9]), .in_second_vel_y(pair[10]), .in_second_vel_z(pair[11]),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .out_first_new_vel_x(new_vel[0]), .out_first_new_vel_y(new_vel[1]),
    .out_first_new_vel_z(new_vel[2]), .out_second_new_vel_x(new_vel[3]),
    .out_second_new_vel_y(new_vel[4]), .out_second_new_vel_z(new_vel[5]),
    .out_collided(out_collided)
  );

  sphere_pair_collision_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pair(pair),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .new_vel(new_vel), .out_collided(out_collided), .fail_count(fail_count),
    .pending(pending), .hit_count(hit_count), .result_count(result_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog on the cycle count.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Present one item and hold it until it is accepted, then maybe idle.
  task automatic send_pair(input logic [11:0][31:0] p);
    start <= 1'b1;
    pair <= p;
    do @(posedge clk); while (busy);
    items_sent++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain the pipeline, then write a new contact distance.
  task automatic set_contact(input logic [spc_pkg::CFG_W-1:0] c);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    contact_now = c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Build a pair from a center offset and two velocities.
  function automatic logic [11:0][31:0] make_pair(input logic [2:0][31:0] p1,
                                                  input logic [2:0][31:0] d,
                                                  input logic [2:0][31:0] v1,
                                                  input logic [2:0][31:0] v2);
    logic [11:0][31:0] p;
    for (int i = 0; i < 3; i++) begin
      p[i] = p1[i];
      p[3+i] = v1[i];
      p[6+i] = p1[i] - d[i];
      p[9+i] = v2[i];
    end
    return p;
  endfunction

  // Random pair, mostly near contact so that the exchange path is exercised.
  function automatic logic [11:0][31:0] random_pair(input logic [spc_pkg::CFG_W-1:0] c);
    logic [2:0][31:0] p1, d, v1, v2;
    int kind;
    int span;
    kind = $urandom_range(9);
    span = (c == 0) ? 2 : int'(c);
    for (int i = 0; i < 3; i++) begin
      p1[i] = $urandom;
      if (kind < 7) d[i] = $signed($urandom_range(2 * span)) - span;
      else if (kind < 9) d[i] = $signed($urandom_range(8 * span)) - 4 * span;
      else d[i] = $urandom;
      v1[i] = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(1 << 20)) - (1 << 19);
      v2[i] = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(1 << 20)) - (1 << 19);
    end
    // Shrink the offset now and then so that it falls inside the sphere.
    if (kind < 4) for (int i = 0; i < 3; i++) d[i] = $signed(d[i]) >>> 1;
    return make_pair(p1, d, v1, v2);
  endfunction

  initial begin
    logic [spc_pkg::CFG_W-1:0] contacts[7];
    int modes[4];
    int per_phase;
    start = 1'b0;
    pair = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    items_sent = 0;
    idle_pct = 0;
    contact_now = spc_pkg::CONTACT_RESET;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset contact distance of 2.0.
    send_pair(make_pair('0, '0, {32'd5, 32'd6, 32'd7}, {32'd1, 32'd2, 32'd3}));
    send_pair(make_pair({32'h7fffffff, 32'h80000000, 32'h0}, {32'h0, 32'h0, 32'd131072},
                        {32'd65536, 32'h0, 32'h0}, {32'h0, 32'h0, -32'sd65536}));
    send_pair(make_pair('0, {32'h0, 32'h0, 32'd131073}, '1, '0));
    send_pair(make_pair('0, {32'd100, 32'd100, 32'd100}, {32'd0, 32'd0, 32'd0},
                        {32'd70000, 32'd30000, 32'd0}));
    send_pair(make_pair('0, {32'd1, 32'd1, 32'd0}, {32'h7fffffff, 32'h7fffffff, 32'h0},
                        {32'h80000000, 32'h80000000, 32'h0}));
    send_pair(make_pair('0, {32'd1, 32'd1, 32'd0}, {32'h80000000, 32'h80000000, 32'h0},
                        {32'h7fffffff, 32'h7fffffff, 32'h0}));
    send_pair(make_pair({32'h80000000, 32'h80000000, 32'h80000000},
                        {32'h7fffffff, 32'h0, 32'h0}, '1, '1));
    send_pair('1);
    send_pair({12{32'h80000000}});
    send_pair({12{32'h7fffffff}});
    send_pair(make_pair('0, {32'd92682, 32'd92682, 32'd0}, {32'd3, 32'd0, 32'd0}, '0));
    send_pair(make_pair('0, {32'd92683, 32'd92682, 32'd0}, {32'd3, 32'd0, 32'd0}, '0));
    send_pair(make_pair('0, {-32'sd1, 32'd2, -32'sd3}, {32'd1, 32'd0, 32'd0}, '0));

    // Random phases over several contact distances and idling patterns.
    contacts = '{spc_pkg::CONTACT_RESET, 24'hffffff, 24'd0, 24'd1, 24'd327680,
                 24'd0, 24'd131072};
    contacts[5] = 24'($urandom_range(24'hffffff));
    modes = '{0, 64, 0, 20};
    per_phase = 190;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) set_contact(contacts[ph]);
      for (int k = 0; k < per_phase; k++) begin
        idle_pct = modes[(ph * per_phase + k) / 47 % 4];
        send_pair(random_pair(contact_now));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Sent %0d pairs over 7 contact distances; %0d results, %0d of them collisions.",
             items_sent, result_count, hit_count);
    if (fail_count == 0 && result_count == items_sent) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
